// File: hdl/sorted_key_table_top_assert.svh
// Assertion macros for the sorted key table checker.
// Needs clk and rst_n in the scope of every use.
`ifndef SORTED_KEY_TABLE_TOP_ASSERT_SVH
`define SORTED_KEY_TABLE_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SKT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted_key_table check failed");

// next-cycle implication, disabled in reset
`define SKT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted_key_table check failed");

`endif

// File: hdl/skt_pkg.sv
// Package for the sorted key table: word types, opcodes, status codes.
// No dependencies.
`default_nettype none
package skt_pkg;

  localparam int DEPTH_DEF = 256;

  typedef enum logic [1:0] {
    OP_FIND   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] key;
    logic [31:0] handle;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  index;
    logic [31:0] found_handle;
    logic [8:0]  entry_count;
  } out_word_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] handle;
  } entry_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage
`default_nettype wire

// File: hdl/skt_ram.sv
// Table storage: one write port, one registered read port.
// Depends on skt_pkg for the entry type.
`default_nettype none
module skt_ram
  import skt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rd_en,
  input  wire logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
  input  wire logic                           wr_en,
  input  wire logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
  input  wire entry_t                         wr_data,
  output entry_t                              rd_data
);

  entry_t mem [TABLE_DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// File: hdl/skt_cmp.sv
// Shared key comparator used by every search and match step.
// Depends on skt_pkg for the result type.
`default_nettype none
module skt_cmp
  import skt_pkg::*;
(
  input  wire logic [31:0] stored_key,
  input  wire logic [31:0] probe_key,
  output cmp_res_t         res
);

  assign res.lt = stored_key < probe_key;
  assign res.eq = stored_key == probe_key;

endmodule
`default_nettype wire

// File: hdl/skt_ctrl.sv
// Sequencer: binary searches, shift loops, count and result word register.
// Depends on skt_pkg, skt_cmp; drives the skt_ram ports.
`default_nettype none
module skt_ctrl
  import skt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire in_word_t                       in_word,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output out_word_t                           out_word,
  output logic                                rd_en,
  output logic [$clog2(TABLE_DEPTH)-1:0]      rd_addr,
  output logic                                wr_en,
  output logic [$clog2(TABLE_DEPTH)-1:0]      wr_addr,
  output entry_t                              wr_data,
  input  wire entry_t                         rd_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_F_RD  = 12'b0000_0000_0010,
    S_F_CMP = 12'b0000_0000_0100,
    S_L_RD  = 12'b0000_0000_1000,
    S_L_CMP = 12'b0000_0001_0000,
    S_R_CHK = 12'b0000_0010_0000,
    S_U_RD  = 12'b0000_0100_0000,
    S_U_WR  = 12'b0000_1000_0000,
    S_PUT   = 12'b0001_0000_0000,
    S_D_RD  = 12'b0010_0000_0000,
    S_D_WR  = 12'b0100_0000_0000,
    S_RESP  = 12'b1000_0000_0000
  } state_t;

  state_t      state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [AW-1:0] mid_r, mid_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [31:0]   key_r, key_nxt;
  logic [31:0]   hnd_in_r, hnd_in_nxt;
  logic [1:0]    res_status_r, res_status_nxt;
  logic [AW-1:0] res_idx_r, res_idx_nxt;
  logic [31:0]   res_hnd_r, res_hnd_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_word_t     out_word_r, out_word_nxt;

  logic [CW:0]   span_sum;
  logic [CW:0]   span_sum_m1;
  logic [AW-1:0] lb_mid;
  logic [AW-1:0] f_mid;
  logic [CW-1:0] mid_p1;
  logic [CW-1:0] f_lo;
  logic [CW-1:0] f_hi;
  cmp_res_t      cmp;

  skt_cmp u_cmp (
    .stored_key (rd_data.key),
    .probe_key  (key_r),
    .res        (cmp)
  );

  assign span_sum    = {1'b0, lo_r} + {1'b0, hi_r};
  assign span_sum_m1 = span_sum - (CW + 1)'(1);
  assign lb_mid      = span_sum[AW:1];
  assign f_mid       = span_sum_m1[AW:1];
  assign mid_p1      = CW'(mid_r) + CW'(1);
  assign f_lo        = cmp.lt ? mid_p1 : lo_r;
  assign f_hi        = cmp.lt ? hi_r : CW'(mid_r);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    pos_nxt        = pos_r;
    j_nxt          = j_r;
    mid_nxt        = mid_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    hnd_in_nxt     = hnd_in_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_hnd_nxt    = res_hnd_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_word_nxt   = out_word_r;
    rd_en          = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = rd_data;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt         = in_word.opcode;
          key_nxt        = in_word.key;
          hnd_in_nxt     = in_word.handle;
          lo_nxt         = '0;
          hi_nxt         = count_r;
          res_status_nxt = ST_MISS;
          res_idx_nxt    = '0;
          res_hnd_nxt    = '0;
          state_nxt      = S_RESP;
          unique case (in_word.opcode)
            OP_FIND: begin
              if (!in_word.key[31] && count_r != '0) begin
                state_nxt = S_F_RD;
              end
            end
            OP_INSERT: begin
              if (count_r == CW'(TABLE_DEPTH)) begin
                res_status_nxt = ST_FULL;
              end else begin
                state_nxt = S_L_RD;
              end
            end
            OP_REMOVE: begin
              state_nxt = S_L_RD;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_F_RD: begin
        rd_en     = 1'b1;
        rd_addr   = f_mid;
        mid_nxt   = f_mid;
        state_nxt = S_F_CMP;
      end
      S_F_CMP: begin
        if (cmp.eq) begin
          res_status_nxt = ST_OK;
          res_idx_nxt    = mid_r;
          res_hnd_nxt    = rd_data.handle;
          state_nxt      = S_RESP;
        end else begin
          lo_nxt    = f_lo;
          hi_nxt    = f_hi;
          state_nxt = (f_lo < f_hi) ? S_F_RD : S_RESP;
        end
      end
      S_L_RD: begin
        if (lo_r == hi_r) begin
          pos_nxt = lo_r;
          if (op_r == OP_INSERT) begin
            j_nxt     = count_r;
            state_nxt = S_U_RD;
          end else if (lo_r == count_r) begin
            state_nxt = S_RESP;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = lo_r[AW-1:0];
            state_nxt = S_R_CHK;
          end
        end else begin
          rd_en     = 1'b1;
          rd_addr   = lb_mid;
          mid_nxt   = lb_mid;
          state_nxt = S_L_CMP;
        end
      end
      S_L_CMP: begin
        if (cmp.lt) begin
          lo_nxt = mid_p1;
        end else begin
          hi_nxt = CW'(mid_r);
        end
        state_nxt = S_L_RD;
      end
      S_R_CHK: begin
        if (cmp.eq) begin
          res_hnd_nxt = rd_data.handle;
          j_nxt       = pos_r;
          state_nxt   = S_D_RD;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_U_RD: begin
        if (j_r == pos_r) begin
          state_nxt = S_PUT;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = AW'(j_r - CW'(1));
          state_nxt = S_U_WR;
        end
      end
      S_U_WR: begin
        wr_en     = 1'b1;
        wr_addr   = j_r[AW-1:0];
        j_nxt     = j_r - CW'(1);
        state_nxt = S_U_RD;
      end
      S_PUT: begin
        wr_en          = 1'b1;
        wr_addr        = pos_r[AW-1:0];
        wr_data        = '{key: key_r, handle: hnd_in_r};
        count_nxt      = count_r + CW'(1);
        res_status_nxt = ST_OK;
        res_idx_nxt    = pos_r[AW-1:0];
        state_nxt      = S_RESP;
      end
      S_D_RD: begin
        if (j_r + CW'(1) == count_r) begin
          count_nxt      = count_r - CW'(1);
          res_status_nxt = ST_OK;
          res_idx_nxt    = pos_r[AW-1:0];
          state_nxt      = S_RESP;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = AW'(j_r + CW'(1));
          state_nxt = S_D_WR;
        end
      end
      S_D_WR: begin
        wr_en     = 1'b1;
        wr_addr   = j_r[AW-1:0];
        j_nxt     = j_r + CW'(1);
        state_nxt = S_D_RD;
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt             = 1'b1;
          out_word_nxt.status       = res_status_r;
          out_word_nxt.index        = 8'(res_idx_r);
          out_word_nxt.found_handle = res_hnd_r;
          out_word_nxt.entry_count  = 9'(count_r);
          state_nxt                 = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    pos_r        <= pos_nxt;
    j_r          <= j_nxt;
    mid_r        <= mid_nxt;
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    hnd_in_r     <= hnd_in_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_hnd_r    <= res_hnd_nxt;
    out_word_r   <= out_word_nxt;
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
`default_nettype wire

// File: hdl/sorted_key_table_top.sv
// Find on an empty table or with key bit 31 set, insert into a full table and opcode 3 go
// straight to the result; other words binary-search the table, insert and remove shift entries.
// One word at a time: the input stalls from acceptance until the result is registered.
// A result waiting on the output holds the next finished word in its last state. Reset
// (rst_n low, synchronous) empties the table and drops any pending result; table contents
// are not cleared, slots above the count unread.
`default_nettype none
module sorted_key_table_top
  import skt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_word
);

  localparam int AW = $clog2(TABLE_DEPTH);

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  entry_t        rd_data;

  skt_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_data   (rd_data)
  );

  skt_ram #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

endmodule
`default_nettype wire

// File: hdl/skt_chk.sv
// Port-level checker for sorted_key_table_top, bound to the top level.
// Depends on skt_pkg and sorted_key_table_top_assert.svh.
`default_nettype none
`include "sorted_key_table_top_assert.svh"
module skt_chk
  import skt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEPTH_DEF
) (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_word_t  in_word,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_word_t out_word
);

  logic in_take;
  assign in_take = in_valid && !in_stall && (in_word.opcode == in_word.opcode);

  `SKT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `SKT_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_word))
  `SKT_ASSERT_NEXT(a_busy_after_take, in_take, in_stall)
  `SKT_ASSERT_NOW(a_full_count, out_valid && out_word.status == ST_FULL,
                  out_word.entry_count == 9'(TABLE_DEPTH) && out_word.index == 8'd0)
  `SKT_ASSERT_NOW(a_miss_zero, out_valid && out_word.status == ST_MISS,
                  out_word.index == 8'd0 && out_word.found_handle == 32'd0)

endmodule

bind sorted_key_table_top skt_chk #(
  .TABLE_DEPTH (TABLE_DEPTH)
) u_skt_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
`default_nettype wire

// File: sim/sorted_key_table_top_tb.sv
`timescale 1ns / 1ps
// Testbench for sorted_key_table_top: directed and random find, insert and remove words
// checked field by field against a behavioral sorted table. Needs skt_pkg and the RTL top.
module sorted_key_table_top_tb;
  import skt_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam logic [1:0] OP_IGNORED = 2'd3;
  localparam int RANDOM_WORDS = 1000;
  localparam int TAIL_CYCLES = 600;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;

  logic [31:0] tbl_key [DEPTH];
  logic [31:0] tbl_handle [DEPTH];
  int tbl_count = 0;

  in_word_t pending_words[$];
  out_word_t expected_results[$];
  out_word_t exp_result;
  int queued_ops = 0;
  int errors = 0;
  logic [31:0] cyc = '0;
  logic calm;

  assign calm = (cyc[14:13] == 2'd2);

  sorted_key_table_top #(
    .TABLE_DEPTH(DEPTH)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word(out_word)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 32'd1;
  end

  function automatic out_word_t apply_op(in_word_t w);
    out_word_t r;
    int lo;
    int hi;
    int mid;
    int pos;
    bit hit;
    r = '0;
    r.status = ST_MISS;
    hit = 1'b0;
    case (w.opcode)
      OP_FIND: begin
        lo = 0;
        hi = tbl_count - 1;
        while (!w.key[31] && !hit && hi >= lo) begin
          mid = (lo + hi) / 2;
          if (w.key > tbl_key[mid]) begin
            lo = mid + 1;
          end else if (w.key < tbl_key[mid]) begin
            hi = mid - 1;
          end else begin
            hit = 1'b1;
            r.status = ST_OK;
            r.index = mid[7:0];
            r.found_handle = tbl_handle[mid];
          end
        end
      end
      OP_INSERT: begin
        if (tbl_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < tbl_count && w.key > tbl_key[pos]) pos++;
          for (int j = tbl_count; j > pos; j--) begin
            tbl_key[j] = tbl_key[j - 1];
            tbl_handle[j] = tbl_handle[j - 1];
          end
          tbl_key[pos] = w.key;
          tbl_handle[pos] = w.handle;
          tbl_count++;
          r.status = ST_OK;
          r.index = pos[7:0];
        end
      end
      OP_REMOVE: begin
        pos = 0;
        while (pos < tbl_count && tbl_key[pos] != w.key) pos++;
        if (pos < tbl_count) begin
          r.status = ST_OK;
          r.index = pos[7:0];
          r.found_handle = tbl_handle[pos];
          for (int j = pos; j < tbl_count - 1; j++) begin
            tbl_key[j] = tbl_key[j + 1];
            tbl_handle[j] = tbl_handle[j + 1];
          end
          tbl_count--;
        end
      end
      default: begin
      end
    endcase
    r.entry_count = tbl_count[8:0];
    return r;
  endfunction

  function automatic logic [31:0] pick_key();
    logic [31:0] k;
    int unsigned sel;
    sel = $urandom_range(99);
    if (tbl_count == 0 || sel < 20) begin
      k = $urandom;
    end else if (sel < 35) begin
      k = $urandom_range(7);
      k[31] = $urandom_range(1);
    end else begin
      k = tbl_key[$urandom_range(tbl_count - 1)];
      if (sel < 45) begin
        k = $urandom_range(1) ? k + 32'd1 : k - 32'd1;
      end
    end
    return k;
  endfunction

  task automatic queue_word(logic [1:0] op, logic [31:0] key, logic [31:0] handle);
    in_word_t w;
    w.opcode = op;
    w.key = key;
    w.handle = handle;
    pending_words.push_back(w);
    if (op != OP_IGNORED) queued_ops++;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_results.push_back(apply_op(in_word));
      if (!in_valid || !in_stall) begin
        if (pending_words.size() != 0 && (calm || $urandom_range(99) >= 25)) begin
          in_valid <= 1'b1;
          in_word <= pending_words.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          if (errors < 10) begin
            $display("ERROR: result with nothing pending: status=%0d index=%0d handle=%h count=%0d",
                     out_word.status, out_word.index, out_word.found_handle,
                     out_word.entry_count);
          end
          errors++;
        end else begin
          exp_result = expected_results.pop_front();
          if (out_word.status !== exp_result.status || out_word.index !== exp_result.index ||
              out_word.found_handle !== exp_result.found_handle ||
              out_word.entry_count !== exp_result.entry_count) begin
            if (errors < 10) begin
              $display("ERROR: status %0d/%0d index %0d/%0d handle %h/%h count %0d/%0d (exp/got)",
                       exp_result.status, out_word.status, exp_result.index, out_word.index,
                       exp_result.found_handle, out_word.found_handle,
                       exp_result.entry_count, out_word.entry_count);
            end
            errors++;
          end
        end
      end
      out_stall <= !calm && ($urandom_range(99) < 25);
    end
  end

  initial begin
    logic [31:0] pool[$];
    logic [1:0] op;
    int sel;
    int n;
    int start;
    int unsigned pick;
    bit filled;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    queue_word(OP_FIND, 32'h0000_0000, 32'h0000_0000);
    queue_word(OP_REMOVE, 32'h0000_0005, 32'h0000_0000);
    queue_word(OP_IGNORED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_word(OP_INSERT, 32'h7FFF_FFFF, 32'hAAAA_AAAA);
    queue_word(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
    queue_word(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_word(OP_INSERT, 32'h7FFF_FFFF, 32'h5555_5555);
    queue_word(OP_INSERT, 32'h8000_0000, 32'h1234_5678);
    queue_word(OP_INSERT, 32'h7FFF_FFFF, 32'h0000_0000);
    queue_word(OP_FIND, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_word(OP_FIND, 32'h7FFF_FFFF, 32'h0000_0000);
    queue_word(OP_FIND, 32'h8000_0000, 32'h0000_0000);
    queue_word(OP_FIND, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_word(OP_FIND, 32'h0000_0001, 32'h0000_0000);
    queue_word(OP_IGNORED, 32'h7FFF_FFFF, 32'h0000_0000);
    queue_word(OP_REMOVE, 32'h7FFF_FFFF, 32'h0000_0000);
    queue_word(OP_REMOVE, 32'h8000_0000, 32'h0000_0000);
    queue_word(OP_REMOVE, 32'h7FFF_FFFF, 32'h0000_0000);
    queue_word(OP_REMOVE, 32'h0000_000C, 32'h0000_0000);
    queue_word(OP_FIND, 32'h7FFF_FFFF, 32'h0000_0000);
    queue_word(OP_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_word(OP_REMOVE, 32'h7FFF_FFFF, 32'h0000_0000);
    queue_word(OP_REMOVE, 32'h0000_0000, 32'h0000_0000);
    queue_word(OP_FIND, 32'h0000_0000, 32'h0000_0000);
    drain();

    start = queued_ops;
    filled = 1'b0;
    while (queued_ops - start < RANDOM_WORDS) begin
      if (!filled && queued_ops - start >= 300) begin
        filled = 1'b1;
        // fill to the top, then hit the full table
        n = DEPTH - tbl_count;
        for (int i = 0; i < n - 1; i++) queue_word(OP_INSERT, pick_key(), $urandom);
        queue_word(OP_INSERT, 32'hFFFF_FFFF, $urandom);
        drain();
        queue_word(OP_REMOVE, 32'hFFFF_FFFF, $urandom);
        queue_word(OP_INSERT, 32'hFFFF_FFFF, $urandom);
        repeat (3) queue_word(OP_INSERT, pick_key(), $urandom);
        repeat (8) queue_word(OP_FIND, pick_key(), $urandom);
        queue_word(OP_IGNORED, $urandom, $urandom);
        drain();
        // drain most entries back out in random order
        pool = {};
        for (int i = 0; i < tbl_count; i++) pool.push_back(tbl_key[i]);
        repeat (DEPTH - 32) begin
          pick = $urandom_range(pool.size() - 1);
          queue_word(OP_REMOVE, pool[pick], $urandom);
          pool.delete(pick);
          if ($urandom_range(3) == 0) queue_word(OP_FIND, pick_key(), $urandom);
        end
        drain();
      end else begin
        repeat (16) begin
          sel = $urandom_range(99);
          if (sel < 4) begin
            op = OP_IGNORED;
          end else if (sel < (tbl_count > 48 ? 24 : 50)) begin
            op = OP_INSERT;
          end else if (sel < (tbl_count > 48 ? 60 : 78)) begin
            op = OP_FIND;
          end else begin
            op = OP_REMOVE;
          end
          queue_word(op, pick_key(), $urandom);
        end
        drain();
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("sorted_key_table_top: match");
    end else begin
      $display("sorted_key_table_top: mismatch");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("sorted_key_table_top: mismatch");
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/skt_pkg.sv
hdl/skt_ram.sv
hdl/skt_cmp.sv
hdl/skt_ctrl.sv
hdl/sorted_key_table_top.sv
hdl/skt_chk.sv
sim/sorted_key_table_top_tb.sv
